// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, the multiplier digit width and small decode helpers.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Bits of the multiplier operand consumed per cycle
  localparam int DIGIT_W = 8;

  // Operation codes
  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_MUL   = 4'd2,
    KIND_DIV   = 4'd3,
    KIND_PLUS  = 4'd4,
    KIND_MINUS = 4'd5,
    KIND_EQ    = 4'd6,
    KIND_NE    = 4'd7,
    KIND_LT    = 4'd8,
    KIND_LE    = 4'd9,
    KIND_GT    = 4'd10,
    KIND_GE    = 4'd11
  } kind_e;

  // Operation needs the cross products
  function automatic logic needs_products(logic [3:0] kind);
    logic res;
    case (kind) inside
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV,
      KIND_LT, KIND_LE, KIND_GT, KIND_GE: res = 1'b1;
      default:                            res = 1'b0;
    endcase
    return res;
  endfunction

  // Operation yields a fraction
  function automatic logic is_arith(logic [3:0] kind);
    logic res;
    case (kind) inside
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV,
      KIND_PLUS, KIND_MINUS: res = 1'b1;
      default:               res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/rau_mult.sv -----
// ----------------------------------------------------------------------------
// rau_mult: digit-serial multiplier
// Forms the low WIDTH bits of x * y, one 8-bit digit of y per cycle, and
// stops as soon as the remaining digits of y are all zero.
// ----------------------------------------------------------------------------
module rau_mult #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int PW = WIDTH + rau_pkg::DIGIT_W;

  logic                         busy_q;
  logic [WIDTH-1:0]             x_q;
  logic [WIDTH-1:0]             y_q;
  logic [WIDTH-1:0]             acc_q;
  logic [rau_pkg::DIGIT_W-1:0]  digit;
  logic [PW-1:0]                part;

  // Partial product of the current digit
  assign digit = y_q[rau_pkg::DIGIT_W-1:0];
  assign part  = PW'(x_q) * PW'(digit);

  assign done_o = busy_q && (y_q == '0);
  assign prod_o = acc_q;

  // Track an active multiplication
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  // Accumulate one digit and advance the operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      acc_q <= '0;
    end else if (busy_q && (y_q != '0)) begin
      acc_q <= acc_q + part[WIDTH-1:0];
      x_q   <= x_q << rau_pkg::DIGIT_W;
      y_q   <= y_q >> rau_pkg::DIGIT_W;
    end
  end

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction arithmetic and comparison
// Each item passes through accept, the cross products (product kinds only,
// digit-serial, stopping early on short operands), form, sign normalization,
// the binary GCD, the numerator and denominator divides, sign restore and
// done. Comparisons and zero denominators skip the GCD and the divides.
// Throughput is one item at a time; the next item is taken the cycle after
// the result is loaded, and a full output register holds the sequencer.
// Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         kind_i,
  input  logic signed [31:0] first_num_i,
  input  logic signed [31:0] first_den_i,
  input  logic signed [31:0] second_num_i,
  input  logic signed [31:0] second_den_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_num_o,
  output logic signed [31:0] result_den_o,
  output logic               compare_true_o,
  output logic               zero_denominator_o
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_MUL_GO   = 10'b0000000010,
    ST_MUL_WAIT = 10'b0000000100,
    ST_FORM     = 10'b0000001000,
    ST_NORM     = 10'b0000010000,
    ST_GCD      = 10'b0000100000,
    ST_DIVN     = 10'b0001000000,
    ST_DIVD     = 10'b0010000000,
    ST_FIN      = 10'b0100000000,
    ST_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  logic [3:0]       kind_q;
  logic [WIDTH-1:0] n1_q, d1_q, n2_q, d2_q;
  logic [WIDTH-1:0] p0_q, p1_q, p2_q;
  logic [1:0]       pidx_q;
  logic [WIDTH-1:0] rn_q, rd_q;
  logic             sn_q, sd_q, cmp_q, zden_q;
  logic [WIDTH-1:0] ga_q, gb_q, g_q;
  logic [CW-1:0]    k_q, cnt_q;
  logic [WIDTH-1:0] rem_q, quo_q;

  logic signed [31:0] result_num_q, result_den_q;
  logic               compare_true_q, zero_denominator_q;

  logic             in_xfer, out_take;
  logic             mul_start, mul_done;
  logic [WIDTH-1:0] mul_x, mul_y, mul_prod;
  logic [WIDTH-1:0] rn_raw, rd_raw;
  logic             cmp_raw;
  logic [WIDTH-1:0] rn_neg, rd_neg, rn_mag, rd_mag;
  logic             sn_norm, sd_norm;
  logic [WIDTH:0]   sub_a, sub_b;
  logic [WIDTH+1:0] diff;
  logic             borrow;
  logic [WIDTH:0]   rem_shift;
  logic [WIDTH-1:0] rem_next, quo_next;
  logic             div_last;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_take   = !out_valid_q || out_ready_i;
  assign mul_start  = (state_q == ST_MUL_GO);

  // Pick the operands of the current cross product
  always_comb begin
    case (pidx_q)
      2'd0: begin
        mul_x = n1_q;
        mul_y = (kind_q == rau_pkg::KIND_MUL) ? n2_q : d2_q;
      end
      2'd1: begin
        mul_x = d1_q;
        mul_y = (kind_q == rau_pkg::KIND_MUL) ? d2_q : n2_q;
      end
      default: begin
        mul_x = d1_q;
        mul_y = d2_q;
      end
    endcase
  end

  rau_mult #(
    .WIDTH (WIDTH)
  ) u_rau_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Form the raw fraction and the comparison outcome
  always_comb begin
    rn_raw  = '0;
    rd_raw  = '0;
    cmp_raw = 1'b0;
    case (kind_q)
      rau_pkg::KIND_ADD:   begin rn_raw = p0_q + p1_q; rd_raw = p2_q; end
      rau_pkg::KIND_SUB:   begin rn_raw = p0_q - p1_q; rd_raw = p2_q; end
      rau_pkg::KIND_MUL:   begin rn_raw = p0_q;        rd_raw = p1_q; end
      rau_pkg::KIND_DIV:   begin rn_raw = p0_q;        rd_raw = p1_q; end
      rau_pkg::KIND_PLUS:  begin rn_raw = n1_q + d1_q; rd_raw = d1_q; end
      rau_pkg::KIND_MINUS: begin rn_raw = n1_q - d1_q; rd_raw = d1_q; end
      rau_pkg::KIND_EQ:    cmp_raw = (n1_q == n2_q) && (d1_q == d2_q);
      rau_pkg::KIND_NE:    cmp_raw = (n1_q != n2_q) || (d1_q != d2_q);
      rau_pkg::KIND_LT:    cmp_raw = $signed(p0_q) < $signed(p1_q);
      rau_pkg::KIND_LE:    cmp_raw = !($signed(p1_q) < $signed(p0_q));
      rau_pkg::KIND_GT:    cmp_raw = $signed(p1_q) < $signed(p0_q);
      rau_pkg::KIND_GE:    cmp_raw = !($signed(p0_q) < $signed(p1_q));
      default:             cmp_raw = 1'b0;
    endcase
  end

  // Sign normalization: magnitudes and the signs after a denominator flip
  assign rn_neg  = '0 - rn_q;
  assign rd_neg  = '0 - rd_q;
  assign rn_mag  = rn_q[WIDTH-1] ? rn_neg : rn_q;
  assign rd_mag  = rd_q[WIDTH-1] ? rd_neg : rd_q;
  assign sn_norm = rd_q[WIDTH-1] ? rn_neg[WIDTH-1] : rn_q[WIDTH-1];
  assign sd_norm = rd_q[WIDTH-1] ? rd_neg[WIDTH-1] : 1'b0;

  // Shared subtractor: GCD difference or divide trial
  assign rem_shift = {rem_q, quo_q[WIDTH-1]};
  always_comb begin
    if (state_q == ST_GCD) begin
      sub_a = {1'b0, ga_q};
      sub_b = {1'b0, gb_q};
    end else begin
      sub_a = rem_shift;
      sub_b = {1'b0, g_q};
    end
  end
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = diff[WIDTH+1];

  // Restoring divide step
  assign rem_next = borrow ? sub_a[WIDTH-1:0] : diff[WIDTH-1:0];
  assign quo_next = {quo_q[WIDTH-2:0], !borrow};
  assign div_last = (cnt_q == CW'(WIDTH - 1));

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rau_pkg::needs_products(kind_i) ? ST_MUL_GO : ST_FORM;
        end
      end
      ST_MUL_GO:   state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          state_d = (pidx_q == 2'd2) ? ST_FORM : ST_MUL_GO;
        end
      end
      ST_FORM: begin
        if (rau_pkg::is_arith(kind_q) && (rd_raw != '0)) begin
          state_d = ST_NORM;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_NORM: state_d = ST_GCD;
      ST_GCD: begin
        if (ga_q == '0) begin
          state_d = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (div_last) begin
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_take) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid: set on a finished item, drop on a transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && out_take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          kind_q <= kind_i;
          n1_q   <= WIDTH'(first_num_i);
          d1_q   <= WIDTH'(first_den_i);
          n2_q   <= WIDTH'(second_num_i);
          d2_q   <= WIDTH'(second_den_i);
          pidx_q <= 2'd0;
        end
      end
      ST_MUL_GO: begin
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          case (pidx_q)
            2'd0:    p0_q <= mul_prod;
            2'd1:    p1_q <= mul_prod;
            default: p2_q <= mul_prod;
          endcase
          pidx_q <= pidx_q + 2'd1;
        end
      end
      ST_FORM: begin
        if (rau_pkg::is_arith(kind_q)) begin
          rn_q   <= rn_raw;
          rd_q   <= rd_raw;
          zden_q <= (rd_raw == '0);
          cmp_q  <= 1'b0;
        end else begin
          rn_q   <= '0;
          rd_q   <= '0;
          zden_q <= 1'b0;
          cmp_q  <= cmp_raw;
        end
      end
      ST_NORM: begin
        rn_q <= rn_mag;
        rd_q <= rd_mag;
        sn_q <= sn_norm;
        sd_q <= sd_norm;
        ga_q <= rn_mag;
        gb_q <= rd_mag;
        k_q  <= '0;
      end
      ST_GCD: begin
        // Binary GCD: strip common twos, then subtract odd values
        if (ga_q == '0) begin
          g_q   <= gb_q << k_q;
          rem_q <= '0;
          quo_q <= rn_q;
          cnt_q <= '0;
        end else if (!ga_q[0] && !gb_q[0]) begin
          ga_q <= ga_q >> 1;
          gb_q <= gb_q >> 1;
          k_q  <= k_q + CW'(1);
        end else if (!ga_q[0]) begin
          ga_q <= ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_q <= gb_q >> 1;
        end else if (borrow) begin
          ga_q <= gb_q;
          gb_q <= ga_q;
        end else begin
          ga_q <= diff[WIDTH-1:0] >> 1;
        end
      end
      ST_DIVN: begin
        if (div_last) begin
          rn_q  <= quo_next;
          rem_q <= '0;
          quo_q <= rd_q;
          cnt_q <= '0;
        end else begin
          rem_q <= rem_next;
          quo_q <= quo_next;
          cnt_q <= cnt_q + CW'(1);
        end
      end
      ST_DIVD: begin
        if (div_last) begin
          rd_q <= quo_next;
        end else begin
          rem_q <= rem_next;
          quo_q <= quo_next;
          cnt_q <= cnt_q + CW'(1);
        end
      end
      ST_FIN: begin
        // Restore the signs on the reduced magnitudes
        rn_q <= sn_q ? rn_neg : rn_q;
        rd_q <= sd_q ? rd_neg : rd_q;
      end
      ST_DONE: begin
        if (out_take) begin
          result_num_q       <= 32'($signed(rn_q));
          result_den_q       <= 32'($signed(rd_q));
          compare_true_q     <= cmp_q;
          zero_denominator_q <= zden_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign result_num_o       = result_num_q;
  assign result_den_o       = result_den_q;
  assign compare_true_o     = compare_true_q;
  assign zero_denominator_o = zero_denominator_q;

endmodule

// ----- rtl/rau_checker.sv -----
// ----------------------------------------------------------------------------
// rau_checker: port-level assertions for the rational arithmetic unit
// Watches the output channel and the consistency of the result flags.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] result_num_o,
  input logic signed [31:0] result_den_o,
  input logic               compare_true_o,
  input logic               zero_denominator_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_num_o)
      && $stable(result_den_o))
    else $error("stalled result changed or dropped");

  // A result is either a comparison or a fraction, never both flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(compare_true_o && zero_denominator_o))
    else $error("compare and zero denominator flags both set");

  // True comparison results carry a zero fraction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> result_num_o == 0 && result_den_o == 0)
    else $error("comparison result with nonzero fraction");

  // A set zero-denominator flag comes with a zero denominator field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_denominator_o |-> result_den_o == 0)
    else $error("zero denominator flag with nonzero denominator");

  // No item is taken while a new result is being loaded for transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after an accepted item");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// ----- verif/tb_rational_arithmetic_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit: self-checking bench for the fraction unit
// Drives a directed table of operands, then random transfers with idle gaps
// on both sides, a long output stall and a full drain. Every result is checked
// field by field against the typed result of its row or an in-bench predictor
// of the reduced fraction or comparison outcome.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;

  localparam int          CLK_HALF      = 6;
  localparam int          RESET_CYCLES  = 9;
  localparam int          RANDOM_ITEMS  = 850;
  localparam int          HOLD_AT       = 200;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          PAUSE_AT      = 400;
  localparam int          QUIET_LO      = 550;
  localparam int          QUIET_HI      = 680;
  localparam int          DRAIN_CYCLES  = 250;
  localparam int          LIMIT_CYCLES  = 1_000_000;
  localparam logic [3:0]  KIND_UNUSED_LO = 4'd12;
  localparam logic [3:0]  KIND_UNUSED_HI = 4'd15;
  localparam logic [31:0] MIN_VAL       = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL       = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_ONE     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        cmp;
    logic        zden;
  } fraction_result_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [31:0]      n1;
    logic [31:0]      d1;
    logic [31:0]      n2;
    logic [31:0]      d2;
    bit               typed;
    fraction_result_t want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [3:0]         kind_i;
  logic signed [31:0] first_num_i;
  logic signed [31:0] first_den_i;
  logic signed [31:0] second_num_i;
  logic signed [31:0] second_den_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] result_num_o;
  logic signed [31:0] result_den_o;
  logic               compare_true_o;
  logic               zero_denominator_o;

  fraction_result_t expected_results[$];
  int               mismatch_count;
  int               accepted_count;
  int               checked_count;
  int               zero_den_count;
  int               true_cmp_count;
  int               cycle_count;
  bit               hold_request;
  bit               quiet_phase;

  rational_arithmetic_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .first_num_i        (first_num_i),
    .first_den_i        (first_den_i),
    .second_num_i       (second_num_i),
    .second_den_i       (second_den_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_num_o       (result_num_o),
    .result_den_o       (result_den_o),
    .compare_true_o     (compare_true_o),
    .zero_denominator_o (zero_denominator_o)
  );

  // Directed operands; typed rows carry a result readable at a glance
  stim_row_t directed_rows [] = '{
    '{rau_pkg::KIND_ADD,   32'd1, 32'd2, 32'd1, 32'd3, 1'b0, '0},
    '{rau_pkg::KIND_SUB,   32'd1, 32'd2, 32'd1, 32'd3, 1'b0, '0},
    '{rau_pkg::KIND_MUL,   32'd2, 32'd3, 32'd3, 32'd4, 1'b0, '0},
    '{rau_pkg::KIND_DIV,   32'd1, 32'd2, 32'd3, 32'd4, 1'b0, '0},
    '{rau_pkg::KIND_PLUS,  32'd0, 32'd1, 32'd0, 32'd0, 1'b1,
      '{32'd1, 32'd1, 1'b0, 1'b0}},
    '{rau_pkg::KIND_MINUS, 32'd0, 32'd1, 32'd0, 32'd0, 1'b1,
      '{MINUS_ONE, 32'd1, 1'b0, 1'b0}},
    '{rau_pkg::KIND_PLUS,  32'd3, 32'd5, MIN_VAL, MINUS_ONE, 1'b0, '0},
    '{rau_pkg::KIND_MINUS, 32'd7, MINUS_ONE, MAX_VAL, 32'd0, 1'b0, '0},
    '{rau_pkg::KIND_EQ,    32'd1, 32'd2, 32'd1, 32'd2, 1'b1,
      '{32'd0, 32'd0, 1'b1, 1'b0}},
    '{rau_pkg::KIND_EQ,    32'd1, 32'd2, 32'd2, 32'd4, 1'b1,
      '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{rau_pkg::KIND_NE,    32'd1, 32'd2, 32'd1, 32'd3, 1'b1,
      '{32'd0, 32'd0, 1'b1, 1'b0}},
    '{rau_pkg::KIND_NE,    32'd1, 32'd2, 32'd1, 32'd2, 1'b1,
      '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{rau_pkg::KIND_LT,    32'd1, 32'd3, 32'd1, 32'd2, 1'b0, '0},
    '{rau_pkg::KIND_LE,    32'd2, 32'd4, 32'd1, 32'd2, 1'b0, '0},
    '{rau_pkg::KIND_GT,    MINUS_ONE, 32'd2, 32'd1, MINUS_ONE, 1'b0, '0},
    '{rau_pkg::KIND_GE,    MIN_VAL, MIN_VAL, MAX_VAL, MAX_VAL, 1'b0, '0},
    '{rau_pkg::KIND_MUL,   32'd3, 32'd0, 32'd5, 32'd7, 1'b1,
      '{32'd15, 32'd0, 1'b0, 1'b1}},
    '{rau_pkg::KIND_DIV,   32'd1, 32'd2, 32'd0, 32'd5, 1'b1,
      '{32'd5, 32'd0, 1'b0, 1'b1}},
    '{rau_pkg::KIND_ADD,   32'd1, 32'hFFFF_FFFE, 32'd1, 32'hFFFF_FFFE, 1'b0, '0},
    '{rau_pkg::KIND_PLUS,  32'd0, MIN_VAL, 32'd0, 32'd0, 1'b0, '0},
    '{rau_pkg::KIND_MUL,   MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, 1'b0, '0},
    '{rau_pkg::KIND_ADD,   MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, 1'b0, '0},
    '{rau_pkg::KIND_SUB,   32'd1, 32'd2, 32'd1, 32'd2, 1'b0, '0},
    '{KIND_UNUSED_LO, 32'd5, 32'd6, 32'd7, 32'd8, 1'b1, '0},
    '{KIND_UNUSED_HI, MINUS_ONE, MINUS_ONE, MINUS_ONE, MINUS_ONE, 1'b1, '0}
  };

  // Predict the reduced fraction or the comparison outcome of one transfer
  function automatic fraction_result_t rational_result(logic [3:0] kind, logic [31:0] n1,
                                                       logic [31:0] d1, logic [31:0] n2,
                                                       logic [31:0] d2);
    logic [31:0]      cross_l;
    logic [31:0]      cross_r;
    logic [31:0]      rn;
    logic [31:0]      rd;
    logic [31:0]      mag_n;
    logic [31:0]      mag_d;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [31:0]      r;
    logic             arith;
    fraction_result_t res;
    res     = '0;
    rn      = '0;
    rd      = '0;
    arith   = 1'b1;
    cross_l = n1 * d2;
    cross_r = d1 * n2;
    case (kind)
      rau_pkg::KIND_ADD:   begin rn = cross_l + cross_r; rd = d2 * d1; end
      rau_pkg::KIND_SUB:   begin rn = cross_l - cross_r; rd = d2 * d1; end
      rau_pkg::KIND_MUL:   begin rn = n1 * n2;           rd = d1 * d2; end
      rau_pkg::KIND_DIV:   begin rn = cross_l;           rd = cross_r; end
      rau_pkg::KIND_PLUS:  begin rn = n1 + d1;           rd = d1; end
      rau_pkg::KIND_MINUS: begin rn = n1 - d1;           rd = d1; end
      default:             arith = 1'b0;
    endcase
    if (arith) begin
      if (rd == '0) begin
        // Leave the fraction as formed and flag it
        res.zden = 1'b1;
      end else begin
        // Move the sign to the numerator, then divide out the GCD
        if (rd[31]) begin
          rn = -rn;
          rd = -rd;
        end
        mag_n = rn[31] ? -rn : rn;
        mag_d = rd[31] ? -rd : rd;
        a = mag_n;
        b = mag_d;
        while (b != '0) begin
          r = a % b;
          a = b;
          b = r;
        end
        rn = rn[31] ? -(mag_n / a) : (mag_n / a);
        rd = rd[31] ? -(mag_d / a) : (mag_d / a);
      end
      res.num = rn;
      res.den = rd;
    end else begin
      case (kind)
        rau_pkg::KIND_EQ: res.cmp = (n1 == n2) && (d1 == d2);
        rau_pkg::KIND_NE: res.cmp = (n1 != n2) || (d1 != d2);
        rau_pkg::KIND_LT: res.cmp = $signed(cross_l) < $signed(cross_r);
        rau_pkg::KIND_LE: res.cmp = !($signed(cross_r) < $signed(cross_l));
        rau_pkg::KIND_GT: res.cmp = $signed(cross_r) < $signed(cross_l);
        rau_pkg::KIND_GE: res.cmp = !($signed(cross_l) < $signed(cross_r));
        default:          res.cmp = 1'b0;
      endcase
    end
    return res;
  endfunction

  // Pick an operand: mostly small, some extremes, some full width
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = int'($urandom_range(40)) - 20;
      5, 6:          v = $urandom;
      7: begin
        case ($urandom_range(4))
          0:       v = MIN_VAL;
          1:       v = MAX_VAL;
          2:       v = '0;
          3:       v = 32'd1;
          default: v = MINUS_ONE;
        endcase
      end
      8:       v = int'($urandom_range(131071)) - 65536;
      default: v = $urandom_range(1) ? (32'd1 << $urandom_range(31))
                                     : -(32'd1 << $urandom_range(31));
    endcase
    return v;
  endfunction

  // Offer one transfer from a falling edge; return at the falling edge after it
  task automatic offer_item(input logic [3:0] kind, input logic [31:0] n1,
                            input logic [31:0] d1, input logic [31:0] n2,
                            input logic [31:0] d2, input bit typed,
                            input fraction_result_t want);
    int gap;
    if (!quiet_phase && $urandom_range(99) < 17) begin
      gap = $urandom_range(6, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    first_num_i  <= n1;
    first_den_i  <= d1;
    second_num_i <= n2;
    second_den_i <= d2;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_results.push_back(typed ? want : rational_result(kind, n1, d1, n2, d2));
    accepted_count++;
    @(negedge clk_i);
  endtask

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Stall the output at random; hold off for a long stretch on request
  initial begin
    int held;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
        hold_request = 1'b0;
      end else begin
        out_ready_i <= quiet_phase || ($urandom_range(99) >= 17);
      end
    end
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    fraction_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d cmp %0b zden %0b", $time,
                 result_num_o, result_den_o, compare_true_o, zero_denominator_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (want.zden) zero_den_count++;
        if (want.cmp)  true_cmp_count++;
        if (result_num_o !== want.num) begin
          $display("%0t: result_num expected %0d got %0d", $time,
                   $signed(want.num), result_num_o);
          mismatch_count++;
        end
        if (result_den_o !== want.den) begin
          $display("%0t: result_den expected %0d got %0d", $time,
                   $signed(want.den), result_den_o);
          mismatch_count++;
        end
        if (compare_true_o !== want.cmp) begin
          $display("%0t: compare_true expected %0b got %0b", $time,
                   want.cmp, compare_true_o);
          mismatch_count++;
        end
        if (zero_denominator_o !== want.zden) begin
          $display("%0t: zero_denominator expected %0b got %0b", $time,
                   want.zden, zero_denominator_o);
          mismatch_count++;
        end
      end
    end
  end

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
             cycle_count, expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Reset, directed table, random traffic, drain
  initial begin
    logic [3:0]  kind;
    logic [31:0] n1;
    logic [31:0] d1;
    logic [31:0] n2;
    logic [31:0] d2;
    mismatch_count = 0;
    accepted_count = 0;
    checked_count  = 0;
    zero_den_count = 0;
    true_cmp_count = 0;
    hold_request   = 1'b0;
    quiet_phase    = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = '0;
    first_num_i    = '0;
    first_den_i    = '0;
    second_num_i   = '0;
    second_den_i   = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].kind, directed_rows[i].n1, directed_rows[i].d1,
                 directed_rows[i].n2, directed_rows[i].d2, directed_rows[i].typed,
                 directed_rows[i].want);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) hold_request = 1'b1;
      // Let the unit drain completely once before going on
      if (i == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk_i);
      end
      quiet_phase = (i >= QUIET_LO) && (i < QUIET_HI);
      if ($urandom_range(99) < 5) begin
        kind = 4'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      end else begin
        kind = 4'($urandom_range(rau_pkg::KIND_GE, rau_pkg::KIND_ADD));
      end
      n1 = random_operand();
      d1 = random_operand();
      n2 = random_operand();
      d2 = random_operand();
      // Repeat the first fraction now and then so equality holds
      if (kind >= rau_pkg::KIND_EQ && $urandom_range(3) == 0) begin
        n2 = n1;
        d2 = d1;
      end
      offer_item(kind, n1, d1, n2, d2, 1'b0, '0);
    end
    in_valid_i  <= 1'b0;
    quiet_phase = 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d transfers in and %0d results checked in %0d cycles,",
             accepted_count, checked_count, cycle_count);
    $display("with %0d zero denominators, %0d true comparisons, %0d mismatches",
             zero_den_count, true_cmp_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- rational_arithmetic_unit.f -----
rtl/rau_pkg.sv
rtl/rau_mult.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
verif/tb_rational_arithmetic_unit.sv
